FILE: src/positional_list_store_defines.svh
// assertion macros shared by the positional list store rtl
// no dependencies; expects clk and rst_n in the including module
`ifndef POSITIONAL_LIST_STORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PLS_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("positional_list_store: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define PLS_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional_list_store: next-cycle check failed");

`endif

FILE: src/pls_pkg.sv
// shared types and codes for the positional list store
// no dependencies
package pls_pkg;

    // field widths fixed by the interface
    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;
    localparam int OCC_W   = 5;

    typedef logic [2:0] op_t;
    typedef logic [1:0] status_t;

    // operation codes
    localparam op_t OP_INS_FIRST = 3'd0;
    localparam op_t OP_INS_LAST  = 3'd1;
    localparam op_t OP_INS_AT    = 3'd2;
    localparam op_t OP_DEL_FIRST = 3'd3;
    localparam op_t OP_DEL_LAST  = 3'd4;
    localparam op_t OP_DEL_AT    = 3'd5;
    localparam op_t OP_DISPLAY   = 3'd6;
    localparam op_t OP_COUNT     = 3'd7;

    // result status codes
    localparam status_t ST_DONE    = 2'd0;
    localparam status_t ST_IGNORED = 2'd1;
    localparam status_t ST_FULL    = 2'd2;

endpackage

FILE: src/positional_list_store.sv
// positional list store: bounded ordered store of signed words with positional edits
// depends on pls_pkg and positional_list_store_defines.svh
//
// A word is taken when start is high and busy is low. Results come out one per
// strobe on result_valid and cannot be held off; last marks the final word of
// an item. The list lives in a memory with one write port and a registered read
// port, so each moved cell needs a read state and a write state. An insert walks
// down from the tail to its zero-based index and a delete walks up from it, one
// cell per read/write pair; display reads the elements out one at a time.
// Count, display of an empty list and every rejected op keep busy low and
// return their result in the next cycle. No clearing pass is needed after reset.
`include "positional_list_store_defines.svh"

module positional_list_store #(
    parameter int CAPACITY = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   op,
    input  logic signed [31:0]           value,
    input  logic [7:0]                   position,
    output logic                         result_valid,
    output logic signed [31:0]           element,
    output logic [4:0]                   occupancy,
    output logic [1:0]                   status,
    output logic                         last
);

    localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int XW  = ((CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W) + 1;
    localparam int OW  = (CW > pls_pkg::OCC_W) ? CW : pls_pkg::OCC_W;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_INS_RD = 7'b0000010,
        S_INS_WR = 7'b0000100,
        S_DEL_RD = 7'b0001000,
        S_DEL_WR = 7'b0010000,
        S_DSP_RD = 7'b0100000,
        S_DSP_OUT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [pls_pkg::VALUE_W-1:0] value_reg, value_next;

    // list memory and its registered read port
    logic [pls_pkg::VALUE_W-1:0] cells [CAPACITY];
    logic [pls_pkg::VALUE_W-1:0] rd_data_reg;
    logic                        mem_we;
    logic [AW-1:0]               mem_waddr;
    logic [AW-1:0]               mem_raddr;
    logic [pls_pkg::VALUE_W-1:0] mem_wdata;

    // result word
    logic                        res_valid_reg, res_valid_next;
    logic [pls_pkg::VALUE_W-1:0] res_elem_reg, res_elem_next;
    logic [pls_pkg::OCC_W-1:0]   res_occ_reg, res_occ_next;
    pls_pkg::status_t            res_status_reg, res_status_next;
    logic                        res_last_reg, res_last_next;

    // widened views for position checks
    logic [XW-1:0] pos_x;
    logic [XW-1:0] fill_x;
    logic [OW-1:0] fill_occ;
    logic [CW-1:0] ptr_inc;
    logic [CW-1:0] ptr_dec;

    assign pos_x    = XW'(position);
    assign fill_x   = XW'(fill_reg);
    assign fill_occ = OW'(fill_next);
    assign ptr_inc  = ptr_reg + 1'b1;
    assign ptr_dec  = ptr_reg - 1'b1;

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign element      = res_elem_reg;
    assign occupancy    = res_occ_reg;
    assign status       = res_status_reg;
    assign last         = res_last_reg;

    // sequencer: decode, then move cells one per read/write pair
    always_comb
    begin
        logic          do_ins;
        logic          do_del;
        logic          bad;
        logic [CW-1:0] tgt;

        do_ins          = 1'b0;
        do_del          = 1'b0;
        bad             = 1'b0;
        tgt             = '0;
        state_next      = state_reg;
        fill_next       = fill_reg;
        ptr_next        = ptr_reg;
        idx_next        = idx_reg;
        value_next      = value_reg;
        mem_we          = 1'b0;
        mem_waddr       = ptr_reg[AW-1:0];
        mem_raddr       = ptr_reg[AW-1:0];
        mem_wdata       = rd_data_reg;
        res_valid_next  = 1'b0;
        res_elem_next   = '0;
        res_status_next = pls_pkg::ST_DONE;
        res_last_next   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    value_next = value;
                    case (op)
                        pls_pkg::OP_INS_FIRST:
                        begin
                            do_ins = 1'b1;
                            tgt    = '0;
                        end
                        pls_pkg::OP_INS_LAST:
                        begin
                            do_ins = 1'b1;
                            tgt    = fill_reg;
                        end
                        pls_pkg::OP_INS_AT:
                        begin
                            bad    = (pos_x == '0) || (pos_x > fill_x + 1'b1);
                            do_ins = !bad;
                            tgt    = CW'(pos_x - 1'b1);
                        end
                        pls_pkg::OP_DEL_FIRST:
                        begin
                            bad    = (fill_reg == '0);
                            do_del = !bad;
                            tgt    = '0;
                        end
                        pls_pkg::OP_DEL_LAST:
                        begin
                            bad    = (fill_reg == '0);
                            do_del = !bad;
                            tgt    = fill_reg - 1'b1;
                        end
                        pls_pkg::OP_DEL_AT:
                        begin
                            bad    = (pos_x == '0) || (pos_x > fill_x);
                            do_del = !bad;
                            tgt    = CW'(pos_x - 1'b1);
                        end
                        pls_pkg::OP_DISPLAY:
                        begin
                            if (fill_reg == '0)
                            begin
                                res_valid_next = 1'b1;
                            end
                            else
                            begin
                                ptr_next   = '0;
                                state_next = S_DSP_RD;
                            end
                        end
                        default:
                        begin
                            res_valid_next = 1'b1;
                        end
                    endcase

                    if (bad)
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = pls_pkg::ST_IGNORED;
                    end
                    else if (do_ins && (fill_reg == CW'(CAPACITY)))
                    begin
                        res_valid_next  = 1'b1;
                        res_status_next = pls_pkg::ST_FULL;
                    end
                    else if (do_ins)
                    begin
                        ptr_next   = fill_reg;
                        idx_next   = tgt;
                        state_next = S_INS_RD;
                    end
                    else if (do_del)
                    begin
                        ptr_next   = tgt;
                        state_next = S_DEL_RD;
                    end
                end
            end

            // walk down from the tail, opening a gap at the target
            S_INS_RD:
            begin
                if (ptr_reg == idx_reg)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = idx_reg[AW-1:0];
                    mem_wdata      = value_reg;
                    fill_next      = fill_reg + 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    mem_raddr  = ptr_dec[AW-1:0];
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg[AW-1:0];
                ptr_next   = ptr_dec;
                state_next = S_INS_RD;
            end

            // walk up from the target, closing the gap
            S_DEL_RD:
            begin
                if (ptr_inc == fill_reg)
                begin
                    fill_next      = fill_reg - 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    mem_raddr  = ptr_inc[AW-1:0];
                    state_next = S_DEL_WR;
                end
            end

            S_DEL_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ptr_reg[AW-1:0];
                ptr_next   = ptr_inc;
                state_next = S_DEL_RD;
            end

            // read out one element per pass
            S_DSP_RD:
            begin
                mem_raddr  = ptr_reg[AW-1:0];
                state_next = S_DSP_OUT;
            end

            S_DSP_OUT:
            begin
                res_valid_next = 1'b1;
                res_elem_next  = rd_data_reg;
                res_last_next  = (ptr_inc == fill_reg);
                if (ptr_inc == fill_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_DSP_RD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        res_occ_next = fill_occ[pls_pkg::OCC_W-1:0];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // working and result payload registers
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        idx_reg        <= idx_next;
        value_reg      <= value_next;
        res_elem_reg   <= res_elem_next;
        res_occ_reg    <= res_occ_next;
        res_status_reg <= res_status_next;
        res_last_reg   <= res_last_next;
    end

    // list memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cells[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= cells[mem_raddr];
    end

    // checks
    `PLS_ASSERT_NOW(a_fill_bound, 1'b1, fill_reg <= CW'(CAPACITY))
    `PLS_ASSERT_NEXT(a_idle_fill_stable, state_reg == S_IDLE, $stable(fill_reg))
    `PLS_ASSERT_NOW(a_more_words_follow, res_valid_reg && !res_last_reg, state_reg == S_DSP_RD)
    `PLS_ASSERT_NEXT(a_insert_reports, (state_reg == S_INS_RD) && (ptr_reg == idx_reg),
        res_valid_reg && (res_status_reg == pls_pkg::ST_DONE) && !busy)

endmodule

FILE: dv/tb_positional_list_store.sv
// self-checking testbench for the positional list store: directed table, then random edits
// depends on pls_pkg and the positional_list_store rtl; predicts result words itself or takes them from the table
module tb_positional_list_store;

    localparam int CAPACITY   = 16;
    localparam int QUIET_MAX  = 2000;
    localparam int DRAIN_WAIT = 40;

    typedef struct packed {
        logic signed [31:0] element;
        logic [4:0]         occupancy;
        pls_pkg::status_t   status;
        logic               last;
    } result_word_t;

    typedef struct packed {
        pls_pkg::op_t     r_op;
        logic [31:0]      r_value;
        logic [7:0]       r_pos;
        logic             fixed;      // expected result typed into the row
        pls_pkg::status_t exp_status;
        logic [4:0]       exp_occ;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         op;
    logic signed [31:0] value;
    logic [7:0]         position;
    logic               result_valid;
    logic signed [31:0] element;
    logic [4:0]         occupancy;
    logic [1:0]         status;
    logic               last;

    // shadow copy of the list and the words still owed by the block
    logic [31:0]    list_cells [CAPACITY];
    int             list_len;
    result_word_t   pending_results [$];
    int             errors;
    int             quiet_cycles;
    bit             grow;

    stim_row_t directed_rows [22] = '{
        '{pls_pkg::OP_DISPLAY,   32'd0,         8'd0,   1'b1, pls_pkg::ST_DONE,    5'd0},
        '{pls_pkg::OP_COUNT,     32'd0,         8'd0,   1'b1, pls_pkg::ST_DONE,    5'd0},
        '{pls_pkg::OP_DEL_FIRST, 32'd0,         8'd0,   1'b1, pls_pkg::ST_IGNORED, 5'd0},
        '{pls_pkg::OP_DEL_LAST,  32'd0,         8'd0,   1'b1, pls_pkg::ST_IGNORED, 5'd0},
        '{pls_pkg::OP_DEL_AT,    32'd0,         8'd1,   1'b1, pls_pkg::ST_IGNORED, 5'd0},
        '{pls_pkg::OP_INS_AT,    32'h1234_5678, 8'd0,   1'b1, pls_pkg::ST_IGNORED, 5'd0},
        '{pls_pkg::OP_INS_AT,    32'h1234_5678, 8'd2,   1'b1, pls_pkg::ST_IGNORED, 5'd0},
        '{pls_pkg::OP_INS_FIRST, 32'h7fff_ffff, 8'd0,   1'b1, pls_pkg::ST_DONE,    5'd1},
        '{pls_pkg::OP_INS_LAST,  32'h8000_0000, 8'd0,   1'b1, pls_pkg::ST_DONE,    5'd2},
        '{pls_pkg::OP_INS_AT,    32'hffff_ffff, 8'd3,   1'b1, pls_pkg::ST_DONE,    5'd3},
        '{pls_pkg::OP_INS_AT,    32'd0,         8'd1,   1'b1, pls_pkg::ST_DONE,    5'd4},
        '{pls_pkg::OP_DISPLAY,   32'd0,         8'd0,   1'b0, pls_pkg::ST_DONE,    5'd0},
        '{pls_pkg::OP_DEL_AT,    32'd0,         8'd0,   1'b1, pls_pkg::ST_IGNORED, 5'd4},
        '{pls_pkg::OP_DEL_AT,    32'd0,         8'd5,   1'b1, pls_pkg::ST_IGNORED, 5'd4},
        '{pls_pkg::OP_DEL_AT,    32'd0,         8'd255, 1'b1, pls_pkg::ST_IGNORED, 5'd4},
        '{pls_pkg::OP_INS_AT,    32'h5555_aaaa, 8'd255, 1'b1, pls_pkg::ST_IGNORED, 5'd4},
        '{pls_pkg::OP_DEL_AT,    32'd0,         8'd2,   1'b1, pls_pkg::ST_DONE,    5'd3},
        '{pls_pkg::OP_DEL_LAST,  32'd0,         8'd0,   1'b1, pls_pkg::ST_DONE,    5'd2},
        '{pls_pkg::OP_DEL_FIRST, 32'd0,         8'd0,   1'b1, pls_pkg::ST_DONE,    5'd1},
        '{pls_pkg::OP_DISPLAY,   32'd0,         8'd0,   1'b0, pls_pkg::ST_DONE,    5'd0},
        '{pls_pkg::OP_COUNT,     32'hffff_ffff, 8'hff,  1'b1, pls_pkg::ST_DONE,    5'd1},
        '{pls_pkg::OP_INS_AT,    32'ha5a5_5a5a, 8'd2,   1'b1, pls_pkg::ST_DONE,    5'd2}
    };

    positional_list_store #(.CAPACITY(CAPACITY)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .value        (value),
        .position     (position),
        .result_valid (result_valid),
        .element      (element),
        .occupancy    (occupancy),
        .status       (status),
        .last         (last)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // shift the tail up and place v at zero-based index idx
    function automatic pls_pkg::status_t list_insert(input int idx, input logic [31:0] v);
        if (idx > list_len)
            return pls_pkg::ST_IGNORED;
        if (list_len >= CAPACITY)
            return pls_pkg::ST_FULL;
        for (int i = list_len; i > idx; i--)
            list_cells[i] = list_cells[i - 1];
        list_cells[idx] = v;
        list_len++;
        return pls_pkg::ST_DONE;
    endfunction

    // close the gap at zero-based index idx
    function automatic pls_pkg::status_t list_remove(input int idx);
        if (idx >= list_len)
            return pls_pkg::ST_IGNORED;
        for (int i = idx; i < list_len - 1; i++)
            list_cells[i] = list_cells[i + 1];
        list_len--;
        return pls_pkg::ST_DONE;
    endfunction

    // update the shadow list and queue the words the block should return
    function automatic void apply_list_op(input pls_pkg::op_t w_op, input logic [31:0] w_value,
                                          input logic [7:0] w_pos);
        pls_pkg::status_t st;
        st = pls_pkg::ST_DONE;
        case (w_op)
            pls_pkg::OP_INS_FIRST: st = list_insert(0, w_value);
            pls_pkg::OP_INS_LAST:  st = list_insert(list_len, w_value);
            pls_pkg::OP_INS_AT:
                st = (w_pos == 0) ? pls_pkg::ST_IGNORED : list_insert(int'(w_pos) - 1, w_value);
            pls_pkg::OP_DEL_FIRST: st = list_remove(0);
            pls_pkg::OP_DEL_LAST:
                st = (list_len == 0) ? pls_pkg::ST_IGNORED : list_remove(list_len - 1);
            pls_pkg::OP_DEL_AT:
                st = (w_pos == 0) ? pls_pkg::ST_IGNORED : list_remove(int'(w_pos) - 1);
            pls_pkg::OP_DISPLAY:
            begin
                if (list_len == 0)
                    pending_results.push_back('{32'sd0, 5'd0, pls_pkg::ST_DONE, 1'b1});
                for (int i = 0; i < list_len; i++)
                    pending_results.push_back('{list_cells[i], list_len[4:0], pls_pkg::ST_DONE,
                                                i == list_len - 1});
                return;
            end
            default: st = pls_pkg::ST_DONE;
        endcase
        pending_results.push_back('{32'sd0, list_len[4:0], st, 1'b1});
    endfunction

    // present one word, hold it until taken, then record what it should produce
    task automatic send_word(input pls_pkg::op_t w_op, input logic [31:0] w_value,
                             input logic [7:0] w_pos, input int idle_pct,
                             input logic fixed, input result_word_t fixed_res);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start    <= 1'b1;
        op       <= w_op;
        value    <= w_value;
        position <= w_pos;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_list_op(w_op, w_value, w_pos);
        // a typed row replaces the single predicted word with its own
        if (fixed)
        begin
            void'(pending_results.pop_back());
            pending_results.push_back(fixed_res);
        end
        @(negedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // random word, biased toward filling or draining the list
    task automatic send_random_word(input int idle_pct);
        int           pick;
        pls_pkg::op_t w_op;
        logic [7:0]   w_pos;
        pick  = $urandom_range(99);
        w_pos = $urandom_range(255);
        if (pick < 8)
            w_op = pls_pkg::OP_DISPLAY;
        else if (pick < 12)
            w_op = pls_pkg::OP_COUNT;
        else if (pick < (grow ? 75 : 35))
        begin
            case ($urandom_range(2))
                0: w_op = pls_pkg::OP_INS_FIRST;
                1: w_op = pls_pkg::OP_INS_LAST;
                default: w_op = pls_pkg::OP_INS_AT;
            endcase
            if ($urandom_range(99) >= 15)
                w_pos = $urandom_range(list_len + 1, 1);
        end
        else
        begin
            case ($urandom_range(2))
                0: w_op = pls_pkg::OP_DEL_FIRST;
                1: w_op = pls_pkg::OP_DEL_LAST;
                default: w_op = pls_pkg::OP_DEL_AT;
            endcase
            if ($urandom_range(99) >= 15)
                w_pos = $urandom_range((list_len > 0) ? list_len : 1, 1);
        end
        send_word(w_op, pick_value(), w_pos, idle_pct, 1'b0, '0);
        // turn around once full has been hit a few times, or once empty
        if (list_len == CAPACITY && $urandom_range(3) == 0)
            grow = 1'b0;
        if (list_len == 0)
            grow = 1'b1;
    endtask

    // result checker: every strobed word against the oldest expectation
    always @(posedge clk)
    begin
        result_word_t exp_word;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word: element %0d occupancy %0d status %0d last %0d",
                       element, occupancy, status, last);
                errors++;
            end
            else
            begin
                exp_word = pending_results.pop_front();
                if (element !== exp_word.element)
                begin
                    $error("element: expected %0d, got %0d", exp_word.element, element);
                    errors++;
                end
                if (occupancy !== exp_word.occupancy)
                begin
                    $error("occupancy: expected %0d, got %0d", exp_word.occupancy, occupancy);
                    errors++;
                end
                if (status !== exp_word.status)
                begin
                    $error("status: expected %0d, got %0d", exp_word.status, status);
                    errors++;
                end
                if (last !== exp_word.last)
                begin
                    $error("last: expected %0d, got %0d", exp_word.last, last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles where neither side moves a word
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        int idle_plan [3];
        int count_plan [3];
        idle_plan    = '{0, 57, 29};
        count_plan   = '{80, 80, 78};
        rst_n        = 1'b0;
        start        = 1'b0;
        op           = pls_pkg::OP_COUNT;
        value        = '0;
        position     = '0;
        list_len     = 0;
        grow         = 1'b1;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table: empty-list cases, extremes, bad positions
        foreach (directed_rows[i])
            send_word(directed_rows[i].r_op, directed_rows[i].r_value, directed_rows[i].r_pos,
                      0, directed_rows[i].fixed,
                      '{32'sd0, directed_rows[i].exp_occ, directed_rows[i].exp_status, 1'b1});

        // random phases with different sender idling
        for (int p = 0; p < 3; p++)
            for (int n = 0; n < count_plan[p]; n++)
                send_random_word(idle_plan[p]);

        // drain and let any stray word show up
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
